// ===== design/brle_pkg.sv =====
// Package for the bit run-length encoder.
// Holds the run record, the lane result struct and shared sizes.
// Used by brle_lane, brle_merge and bit_run_length_encoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brle_pkg;

  localparam int unsigned LenW       = 8;
  localparam int unsigned NumLanes   = 8;
  // One slot per lane plus the flushed final run.
  localparam int unsigned NumEntries = NumLanes + 1;
  localparam int unsigned FlushIdx   = NumLanes;
  localparam int unsigned OutDataW   = 16;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic            run_bit;
  } run_t;

  typedef struct packed {
    logic emit;
    run_t run;
  } lane_out_t;

endpackage

`default_nettype wire

// ===== design/brle_lane.sv =====
// One bit lane of the bit run-length encoder.
// Extends or closes the open run with one incoming bit; depends on brle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brle_lane #(
  parameter int unsigned MAX_RUN = 255
) (
  input  logic              bit_i,
  input  brle_pkg::run_t    open_i,
  output brle_pkg::run_t    open_o,
  output brle_pkg::lane_out_t res_o
);

  localparam logic [brle_pkg::LenW-1:0] MaxRun = brle_pkg::LenW'(MAX_RUN);

  always_comb begin
    res_o.emit = 1'b0;
    res_o.run  = open_i;
    if (open_i.len == '0) begin
      open_o.len     = brle_pkg::LenW'(1);
      open_o.run_bit = bit_i;
    end else if ((bit_i != open_i.run_bit) || (open_i.len >= MaxRun)) begin
      res_o.emit     = 1'b1;
      open_o.len     = brle_pkg::LenW'(1);
      open_o.run_bit = bit_i;
    end else begin
      open_o.len     = open_i.len + brle_pkg::LenW'(1);
      open_o.run_bit = open_i.run_bit;
    end
  end

endmodule

`default_nettype wire

// ===== design/brle_merge.sv =====
// Merging stage of the bit run-length encoder.
// Holds the runs found by the lanes and sends them out in order through an
// output register; depends on brle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brle_merge (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic [brle_pkg::NumEntries-1:0]        emit_i,
  input  brle_pkg::run_t [brle_pkg::NumEntries-1:0] runs_i,
  output logic                                   idle_o,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [brle_pkg::OutDataW-1:0]          m_axis_tdata_o,
  output logic                                   m_axis_tlast_o
);

  logic [brle_pkg::NumEntries-1:0]         pend_q, pend_d;
  brle_pkg::run_t [brle_pkg::NumEntries-1:0] ent_q, ent_d;
  logic [brle_pkg::NumEntries-1:0]         sel;
  logic                                    move;
  brle_pkg::run_t                          sel_run;
  logic                                    out_valid_q, out_valid_d;
  brle_pkg::run_t                          out_run_q, out_run_d;
  logic                                    out_last_q, out_last_d;

  // Lowest pending slot is the oldest run.
  assign sel  = pend_q & (~pend_q + brle_pkg::NumEntries'(1));
  assign move = (pend_q != '0) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    sel_run = '0;
    for (int i = 0; i < brle_pkg::NumEntries; i++) begin
      if (sel[i]) begin
        sel_run = sel_run | ent_q[i];
      end
    end
  end

  // A new request may be taken once the last pending run leaves this cycle.
  assign idle_o = (pend_q == '0) ||
                  (((pend_q & (pend_q - brle_pkg::NumEntries'(1))) == '0) && move);

  always_comb begin
    pend_d      = pend_q;
    ent_d       = ent_q;
    out_valid_d = out_valid_q;
    out_run_d   = out_run_q;
    out_last_d  = out_last_q;
    if (move) begin
      pend_d      = pend_q & ~sel;
      out_valid_d = 1'b1;
      out_run_d   = sel_run;
      out_last_d  = sel[brle_pkg::FlushIdx];
    end else if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_i) begin
      pend_d = emit_i;
      ent_d  = runs_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    out_run_q  <= out_run_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(brle_pkg::OutDataW - brle_pkg::LenW - 1){1'b0}},
                            out_run_q.run_bit, out_run_q.len};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== design/bit_run_length_encoder.sv =====
// Top level of the bit run-length encoder.
// Eight brle_lane instances scan a byte, brle_merge sends the runs out;
// depends on brle_pkg.
//
//  Channel  | Direction | tdata (low bit up)            | tlast
//  s_axis   | in        | [7:0] data_byte               | final_byte
//  m_axis   | out       | [7:0] run_length, [8] run_bit | last_run
//
// All eight bits of a byte are scanned in the cycle it is accepted; its runs
// (up to nine) then leave the merging stage's buffer one per cycle while the
// output is ready. The next byte is taken as the last run leaves, so the
// output port sets the rate. Reset discards any open run and empties the
// buffer. A stalled output holds the buffer; input is refused until it drains.
`timescale 1ns / 1ps
`default_nettype none

module bit_run_length_encoder #(
  parameter int unsigned MAX_RUN = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] run_length, [8] run_bit
  output logic        m_axis_tlast_o    // last_run
);

  brle_pkg::run_t                            open_q, open_d;
  brle_pkg::run_t [brle_pkg::NumLanes:0]     chain;
  brle_pkg::lane_out_t [brle_pkg::NumLanes-1:0] lane_res;
  logic [brle_pkg::NumEntries-1:0]           emit;
  brle_pkg::run_t [brle_pkg::NumEntries-1:0] runs;
  logic                                      idle;
  logic                                      accept;

  assign chain[0] = open_q;

  // Lane k takes bit 7-k, so the most significant bit is seen first.
  for (genvar k = 0; k < brle_pkg::NumLanes; k++) begin : g_lane
    brle_lane #(
      .MAX_RUN(MAX_RUN)
    ) u_lane (
      .bit_i (s_axis_tdata_i[brle_pkg::NumLanes-1-k]),
      .open_i(chain[k]),
      .open_o(chain[k+1]),
      .res_o (lane_res[k])
    );
    assign emit[k] = lane_res[k].emit;
    assign runs[k] = lane_res[k].run;
  end

  assign emit[brle_pkg::FlushIdx] = s_axis_tlast_i;
  assign runs[brle_pkg::FlushIdx] = chain[brle_pkg::NumLanes];

  assign s_axis_tready_o = idle;
  assign accept          = s_axis_tvalid_i && idle;

  always_comb begin
    open_d = open_q;
    if (accept) begin
      open_d = s_axis_tlast_i ? '0 : chain[brle_pkg::NumLanes];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  brle_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .emit_i         (emit),
    .runs_i         (runs),
    .idle_o         (idle),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
